@@ hdl/lpca_pkg.sv @@
// Shared types and constants of the line position cluster averaging block.
`default_nettype none
package lpca_pkg;

  localparam int POS_W   = 20;
  localparam int CNT_W   = 8;
  localparam int CMD_W   = 2;
  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 6;
  localparam int IDX_W   = 6;
  localparam int RANK_W  = 7;
  localparam int MAX_OUT = 64;
  localparam int NUM_W   = POS_W + CNT_W + 1;
  localparam int DEN_W   = CNT_W + 1;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ADD_FIRST = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_LATER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH    = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_LINE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RECORD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

  // Register indexes
  localparam logic REG_MERGE_LIMIT = 1'b0;
  localparam logic REG_GRID_COUNT  = 1'b1;

  localparam logic [POS_W-1:0] MERGE_LIMIT_RST = 20'd4352;
  localparam logic [CNT_W-1:0] GRID_COUNT_RST  = 8'd1;
  localparam logic [CNT_W-1:0] CNT_MAX         = 8'd255;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] position;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [IDX_W-1:0]  out_index;
    logic [POS_W-1:0]  mean_position;
    logic [CNT_W-1:0]  member_count;
    logic              overflow;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0] mean;
    logic [CNT_W-1:0] count;
  } entry_t;

endpackage
`default_nettype wire

@@ hdl/lpca_table.sv @@
// Cluster entry memory: one write port, one registered read port.
`default_nettype none
module lpca_table
  import lpca_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [DEPTH];

  // Write entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read entry, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/lpca_div.sv @@
// Restoring divider, one quotient bit per cycle, for the running mean.
`default_nettype none
module lpca_div
  import lpca_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [POS_W-1:0]      quo
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [NUM_W-1:0]  n_r;
  logic [NUM_W-1:0]  q_r;
  logic [DEN_W-1:0]  d_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W:0]    rem2;
  logic              ge;

  assign rem2 = {rem_r, n_r[NUM_W-1]};
  assign ge   = rem2 >= {1'b0, d_r};
  assign done = busy_r && (step_r == '0);
  assign quo  = q_r[POS_W-1:0];

  // Track busy and remaining steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= STEP_W'(NUM_W);
    end else if (busy_r) begin
      if (step_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        step_r <= step_r - 1'b1;
      end
    end
  end

  // Shift in one numerator bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      d_r   <= den;
      q_r   <= '0;
      rem_r <= '0;
    end else if (busy_r && (step_r != '0)) begin
      n_r <= {n_r[NUM_W-2:0], 1'b0};
      q_r <= {q_r[NUM_W-2:0], ge};
      if (ge) begin
        rem_r <= DEN_W'(rem2 - {1'b0, d_r});
      end else begin
        rem_r <= rem2[DEN_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/line_position_cluster_average_unit.sv @@
// Top level: line clustering control, scan, finish sort and ports.
//
//  port group | direction | handshake            | payload
//  in_        | input     | in_valid / in_stall  | in_data  (in_item_t)
//  out_       | output    | out_valid / out_stall| out_data (out_item_t)
//  cfg (APB)  | input     | psel/penable/pwrite  | paddr, pwdata, prdata
//
// A first-grid line goes straight to the decide and output states; a
// later-grid line scans the used entries through the table read port,
// then on a merge runs the serial divider.
// Finish runs one counting pass and one selection pass per kept cluster,
// each over the used entries, through the table read port.
// Reset clears the fill count; entry contents are only read below it.
// A stalled result holds in the output register; the next item is taken
// meanwhile, and emission waits until that register frees.
`default_nettype none
module line_position_cluster_average_unit
  import lpca_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = AW + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_DIVGO  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  localparam logic [1:0] M_INS = 2'd0;
  localparam logic [1:0] M_CNT = 2'd1;
  localparam logic [1:0] M_SEL = 2'd2;

  logic [2:0]       state_r;
  logic [1:0]       mode_r;
  logic [POS_W-1:0] limit_r;
  logic [CNT_W-1:0] grid_r;
  logic [CW-1:0]    used_r;
  logic [POS_W-1:0] pos_r;
  logic [CW-1:0]    scan_r;
  logic             pend_r;
  logic [AW-1:0]    pslot_r;
  logic             best_v_r;
  logic [AW-1:0]    best_s_r;
  logic [POS_W-1:0] best_m_r;
  logic [CNT_W-1:0] best_c_r;
  logic [POS_W-1:0] best_d_r;
  logic [CW-1:0]    nkept_r;
  logic [RANK_W-1:0] n_r;
  logic [RANK_W-1:0] rank_r;
  logic             prev_v_r;
  logic [AW-1:0]    prev_s_r;
  logic [POS_W-1:0] prev_m_r;
  out_item_t        res_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  entry_t           rdata;
  logic             we;
  logic [AW-1:0]    waddr;
  entry_t           wdata;
  logic             div_start;
  logic             div_done;
  logic [POS_W-1:0] div_quo;
  logic [NUM_W-1:0] num;
  logic [CNT_W-1:0] half;
  logic [POS_W-1:0] gap;
  logic             kept;
  logic             after_prev;
  logic             before_best;
  logic             scan_end;
  logic             accept;
  logic             out_free;
  logic [RANK_W-1:0] n_calc;
  logic [SLOT_W+AW-1:0] best_slot_ext;
  logic [SLOT_W+AW-1:0] used_slot_ext;

  lpca_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (scan_r[AW-1:0]),
    .rdata (rdata)
  );

  lpca_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   ({1'b0, best_c_r} + 1'b1),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = 32'd0;
    case (paddr[2])
      REG_MERGE_LIMIT: prdata = {12'd0, limit_r};
      REG_GRID_COUNT:  prdata = {24'd0, grid_r};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= MERGE_LIMIT_RST;
      grid_r  <= GRID_COUNT_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_MERGE_LIMIT: limit_r <= pwdata[POS_W-1:0];
        REG_GRID_COUNT:  grid_r  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and scan helpers
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign scan_end  = (scan_r == used_r) && !pend_r;
  assign half      = grid_r >> 1;
  assign gap       = (rdata.mean > pos_r) ? rdata.mean - pos_r : pos_r - rdata.mean;
  assign kept      = rdata.count > half;
  assign after_prev  = !prev_v_r || (rdata.mean > prev_m_r) ||
                       ((rdata.mean == prev_m_r) && (pslot_r > prev_s_r));
  assign before_best = !best_v_r || (rdata.mean < best_m_r) ||
                       ((rdata.mean == best_m_r) && (pslot_r < best_s_r));
  assign num       = NUM_W'(best_c_r) * NUM_W'(best_m_r) + NUM_W'(pos_r);
  assign div_start = (state_r == S_DIVGO);
  assign n_calc    = (nkept_r > CW'(MAX_OUT)) ? RANK_W'(MAX_OUT) : RANK_W'(nkept_r);
  assign best_slot_ext = {{SLOT_W{1'b0}}, best_s_r};
  assign used_slot_ext = {{SLOT_W{1'b0}}, used_r[AW-1:0]};

  // Table writes: merged mean or new entry
  always_comb begin
    we    = 1'b0;
    waddr = best_s_r;
    wdata.mean  = div_quo;
    wdata.count = (best_c_r == CNT_MAX) ? CNT_MAX : best_c_r + 1'b1;
    if ((state_r == S_DIV) && div_done) begin
      we = 1'b1;
    end else if ((state_r == S_DECIDE) &&
                 !(best_v_r && (best_d_r < limit_r)) &&
                 (used_r < CW'(TABLE_DEPTH))) begin
      we          = 1'b1;
      waddr       = used_r[AW-1:0];
      wdata.mean  = pos_r;
      wdata.count = CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && out_free) begin
      out_data_r <= res_r;
    end
  end

  // Control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= M_INS;
      used_r   <= '0;
      scan_r   <= '0;
      pend_r   <= 1'b0;
      best_v_r <= 1'b0;
      prev_v_r <= 1'b0;
      nkept_r  <= '0;
      n_r      <= '0;
      rank_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            pos_r    <= in_data.position;
            scan_r   <= '0;
            pend_r   <= 1'b0;
            best_v_r <= 1'b0;
            prev_v_r <= 1'b0;
            nkept_r  <= '0;
            rank_r   <= '0;
            case (in_data.command)
              CMD_ADD_FIRST: state_r <= S_DECIDE;
              CMD_ADD_LATER: begin
                mode_r  <= M_INS;
                state_r <= S_SCAN;
              end
              CMD_FINISH: begin
                mode_r  <= M_CNT;
                state_r <= S_SCAN;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end

        S_SCAN: begin
          // Issue next read, fold in the entry read last cycle
          if (scan_r != used_r) begin
            pend_r  <= 1'b1;
            pslot_r <= scan_r[AW-1:0];
            scan_r  <= scan_r + 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
          if (pend_r) begin
            case (mode_r)
              M_INS: begin
                if (!best_v_r || (gap < best_d_r) ||
                    ((gap == best_d_r) && (rdata.mean > best_m_r))) begin
                  best_v_r <= 1'b1;
                  best_s_r <= pslot_r;
                  best_m_r <= rdata.mean;
                  best_c_r <= rdata.count;
                  best_d_r <= gap;
                end
              end
              M_CNT: begin
                if (kept) nkept_r <= nkept_r + 1'b1;
              end
              M_SEL: begin
                if (kept && after_prev && before_best) begin
                  best_v_r <= 1'b1;
                  best_s_r <= pslot_r;
                  best_m_r <= rdata.mean;
                  best_c_r <= rdata.count;
                end
              end
              default: ;
            endcase
          end
          if (scan_end) begin
            case (mode_r)
              M_INS: state_r <= S_DECIDE;
              M_CNT: begin
                n_r <= n_calc;
                if (n_calc == '0) begin
                  res_r   <= '{kind: KIND_EMPTY, slot: '0, out_index: '0,
                               mean_position: '0, member_count: '0,
                               overflow: 1'b0, last: 1'b1};
                  used_r  <= '0;
                  state_r <= S_OUT;
                end else begin
                  mode_r   <= M_SEL;
                  scan_r   <= '0;
                  best_v_r <= 1'b0;
                end
              end
              M_SEL: begin
                res_r <= '{kind: KIND_RECORD, slot: best_slot_ext[SLOT_W-1:0],
                           out_index: rank_r[IDX_W-1:0], mean_position: best_m_r,
                           member_count: best_c_r, overflow: 1'b0,
                           last: (rank_r == n_r - 1'b1)};
                if (rank_r == n_r - 1'b1) used_r <= '0;
                prev_v_r <= 1'b1;
                prev_s_r <= best_s_r;
                prev_m_r <= best_m_r;
                rank_r   <= rank_r + 1'b1;
                state_r  <= S_OUT;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end

        S_DECIDE: begin
          if (best_v_r && (best_d_r < limit_r)) begin
            state_r <= S_DIVGO;
          end else if (used_r >= CW'(TABLE_DEPTH)) begin
            res_r   <= '{kind: KIND_LINE, slot: '0, out_index: '0,
                         mean_position: '0, member_count: '0,
                         overflow: 1'b1, last: 1'b1};
            state_r <= S_OUT;
          end else begin
            res_r   <= '{kind: KIND_LINE, slot: used_slot_ext[SLOT_W-1:0],
                         out_index: '0, mean_position: pos_r,
                         member_count: CNT_W'(1), overflow: 1'b0, last: 1'b1};
            used_r  <= used_r + 1'b1;
            state_r <= S_OUT;
          end
        end

        S_DIVGO: state_r <= S_DIV;

        S_DIV: begin
          if (div_done) begin
            res_r   <= '{kind: KIND_LINE, slot: best_slot_ext[SLOT_W-1:0],
                         out_index: '0, mean_position: wdata.mean,
                         member_count: wdata.count, overflow: 1'b0, last: 1'b1};
            state_r <= S_OUT;
          end
        end

        S_OUT: begin
          // Hand the result over, then end or run the next selection pass
          if (out_free) begin
            if (res_r.last) begin
              state_r <= S_IDLE;
            end else begin
              scan_r   <= '0;
              pend_r   <= 1'b0;
              best_v_r <= 1'b0;
              state_r  <= S_SCAN;
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
